// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the lattice propagator stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int unsigned MaxSitesDef = 64;  // default lattice capacity
  localparam int unsigned SiteW       = 7;   // site index / count width
  localparam int unsigned DataW       = 32;  // Q8.24 data width
  localparam int unsigned CoefW       = 25;  // Q1.24 neighbor weight width
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned FracW       = 24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWeightBack = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWeightFwd  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSites      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLeftMirror = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRightMirr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTwoChain   = 3'd5;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load_we;   // store one loaded site
    logic shift;     // shift old-value window, latch weight and mask
    logic st1;       // neighbor difference products
    logic st2;       // accumulate and round
    logic st3;       // weight products
    logic st_wr;     // saturate and write new values
    logic out_ld;    // load output data register
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lps_datapath.sv -----
// ----------------------------------------------------------------------------
// lps_datapath
// Site memories, three-site window and two-lane stencil pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_datapath #(
  parameter int unsigned MaxSites = lps_pkg::MaxSitesDef,
  parameter int unsigned AddrW    = (MaxSites > 1) ? $clog2(MaxSites) : 1
) (
  input  wire logic                       clk_i,
  input  wire lps_pkg::ctl_t              ctl_i,
  input  wire logic [AddrW-1:0]           ld_addr_i,
  input  wire logic [AddrW-1:0]           rd_addr_i,
  input  wire logic [AddrW-1:0]           wt_addr_i,
  input  wire logic [AddrW-1:0]           wr_addr_i,
  input  wire logic [AddrW-1:0]           em_addr_i,
  input  wire logic [lps_pkg::DataW-1:0]  site_weight_i,
  input  wire logic [lps_pkg::DataW-1:0]  chain1_prev_i,
  input  wire logic [lps_pkg::DataW-1:0]  chain2_prev_i,
  input  wire logic                       in_range_i,
  input  wire logic [lps_pkg::CoefW-1:0]  weight_back_i,
  input  wire logic [lps_pkg::CoefW-1:0]  weight_fwd_i,
  input  wire logic                       two_chain_i,
  output logic      [lps_pkg::DataW-1:0]  chain1_new_o,
  output logic      [lps_pkg::DataW-1:0]  chain2_new_o
);
  import lps_pkg::*;

  localparam int unsigned SumW  = DataW + 1;        // a1+a2
  localparam int unsigned DiffW = DataW + 2;        // signed difference
  localparam int unsigned ProdW = CoefW + 1 + DiffW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned InnW  = AccW - FracW;
  localparam int unsigned HiW   = InnW - FracW;
  localparam logic signed [AccW-1:0] HalfAcc = AccW'(1) <<< (FracW - 1);
  localparam logic [DataW+FracW-1:0] HalfLo  = (DataW+FracW)'(1) << (FracW - 1);

  // site memories
  logic [DataW-1:0] wt_mem  [MaxSites];
  logic [DataW-1:0] old1_mem[MaxSites];
  logic [DataW-1:0] old2_mem[MaxSites];
  logic             msk_mem [MaxSites];
  logic [DataW-1:0] new1_mem[MaxSites];
  logic [DataW-1:0] new2_mem[MaxSites];

  logic [DataW-1:0] rd1_q, rd2_q, wrd_q, em1_q, em2_q;
  logic             mrd_q;

  logic [DataW-1:0] wr1, wr2;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_we) begin
      wt_mem[ld_addr_i]   <= site_weight_i;
      old1_mem[ld_addr_i] <= chain1_prev_i;
      old2_mem[ld_addr_i] <= chain2_prev_i;
      msk_mem[ld_addr_i]  <= in_range_i;
    end
    rd1_q <= old1_mem[rd_addr_i];
    rd2_q <= old2_mem[rd_addr_i];
    wrd_q <= wt_mem[wt_addr_i];
    mrd_q <= msk_mem[wt_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.st_wr) begin
      new1_mem[wr_addr_i] <= wr1;
      new2_mem[wr_addr_i] <= wr2;
    end
    em1_q <= new1_mem[em_addr_i];
    em2_q <= new2_mem[em_addr_i];
  end

  // three-site window per chain, plus weight and mask of the center site
  logic [DataW-1:0] a1_q, b1_q, c1_q, a2_q, b2_q, c2_q, w_q;
  logic             m_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      a1_q <= b1_q;
      b1_q <= c1_q;
      c1_q <= rd1_q;
      a2_q <= b2_q;
      b2_q <= c2_q;
      c2_q <= rd2_q;
      w_q  <= wrd_q;
      m_q  <= mrd_q;
    end
  end

  // lane 0 is chain one, lane 1 is chain two
  logic                    coupled;
  logic [SumW-1:0]         la  [2];
  logic [SumW-1:0]         lc  [2];
  logic [DataW-1:0]        lb  [2];
  logic signed [DiffW-1:0] dab [2];
  logic signed [DiffW-1:0] dcb [2];

  logic signed [ProdW-1:0] pb_q [2];
  logic signed [ProdW-1:0] pf_q [2];
  logic [DataW-1:0]        bs_q [2];
  logic                    zero2_s1_q, zero2_s2_q, zero2_s3_q;

  always_comb begin
    coupled = two_chain_i & m_q;
    la[0] = coupled ? (SumW'(a1_q) + SumW'(a2_q)) : SumW'(a1_q);
    lc[0] = coupled ? (SumW'(c1_q) + SumW'(c2_q)) : SumW'(c1_q);
    lb[0] = b1_q;
    la[1] = SumW'(a2_q);
    lc[1] = SumW'(c2_q);
    lb[1] = b2_q;
    for (int i = 0; i < 2; i++) begin
      dab[i] = $signed({1'b0, la[i]}) - $signed({2'b00, lb[i]});
      dcb[i] = $signed({1'b0, lc[i]}) - $signed({2'b00, lb[i]});
    end
  end

  // stage 1: neighbor difference products
  always_ff @(posedge clk_i) begin
    if (ctl_i.st1) begin
      for (int i = 0; i < 2; i++) begin
        pb_q[i] <= $signed({1'b0, weight_back_i}) * dab[i];
        pf_q[i] <= $signed({1'b0, weight_fwd_i}) * dcb[i];
        bs_q[i] <= lb[i];
      end
      zero2_s1_q <= ~two_chain_i | coupled;
    end
  end

  // stage 2: accumulate in Q.48 and round to Q.24
  logic signed [AccW-1:0] acc [2];
  logic signed [AccW-1:0] accr[2];
  logic [InnW-1:0]        inn_q[2];
  logic                   pos_q[2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      acc[i]  = $signed({(AccW-DataW-FracW)'(0), bs_q[i], FracW'(0)})
              + AccW'(pb_q[i]) + AccW'(pf_q[i]);
      accr[i] = acc[i] + HalfAcc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.st2) begin
      for (int i = 0; i < 2; i++) begin
        inn_q[i] <= accr[i][AccW-1:FracW];
        pos_q[i] <= (acc[i] > 0);
      end
      zero2_s2_q <= zero2_s1_q;
    end
  end

  // stage 3: site weight times integer and fraction parts
  logic [DataW+HiW-1:0]   ph_q[2];
  logic [DataW+FracW-1:0] pl_q[2];
  logic                   pos3_q[2];

  always_ff @(posedge clk_i) begin
    if (ctl_i.st3) begin
      for (int i = 0; i < 2; i++) begin
        ph_q[i]   <= w_q * inn_q[i][InnW-1:FracW];
        pl_q[i]   <= w_q * inn_q[i][FracW-1:0];
        pos3_q[i] <= pos_q[i];
      end
      zero2_s3_q <= zero2_s2_q;
    end
  end

  // stage 4: combine, clamp at zero, saturate
  logic [DataW+FracW-1:0] plr [2];
  logic [DataW+HiW:0]     prod[2];
  logic [DataW-1:0]       res [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      plr[i]  = pl_q[i] + HalfLo;
      prod[i] = (DataW+HiW+1)'(ph_q[i]) + (DataW+HiW+1)'(plr[i][DataW+FracW-1:FracW]);
      if (!pos3_q[i]) begin
        res[i] = '0;
      end else if (prod[i][DataW+HiW:DataW] != '0) begin
        res[i] = '1;
      end else begin
        res[i] = prod[i][DataW-1:0];
      end
    end
    wr1 = res[0];
    wr2 = zero2_s3_q ? '0 : res[1];
  end

  // output data register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_ld) begin
      chain1_new_o <= em1_q;
      chain2_new_o <= em2_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lps_ctrl.sv -----
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer: load pass, window priming, per-site stencil steps, emit pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_ctrl #(
  parameter int unsigned MaxSites = lps_pkg::MaxSitesDef,
  parameter int unsigned AddrW    = (MaxSites > 1) ? $clog2(MaxSites) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      in_last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [lps_pkg::SiteW-1:0] site_index_o,
  output logic                           last_result_o,
  input  wire logic [lps_pkg::SiteW-1:0] sites_in_use_i,
  input  wire logic [lps_pkg::SiteW-1:0] left_mirror_i,
  input  wire logic [lps_pkg::SiteW-1:0] right_mirror_i,
  output lps_pkg::ctl_t                  ctl_o,
  output logic      [AddrW-1:0]          ld_addr_o,
  output logic      [AddrW-1:0]          rd_addr_o,
  output logic      [AddrW-1:0]          wt_addr_o,
  output logic      [AddrW-1:0]          wr_addr_o,
  output logic      [AddrW-1:0]          em_addr_o
);
  import lps_pkg::*;

  localparam logic [SiteW-1:0] MaxS = SiteW'(MaxSites);

  typedef enum logic [3:0] {
    S_LOAD, S_RD, S_SH, S_M1, S_M2, S_M3, S_M4, S_ERD, S_ELD, S_EWT
  } state_e;

  state_e           state_q, state_d;
  logic [SiteW-1:0] cnt_q, cnt_d;   // load count
  logic [SiteW-1:0] ptr_q, ptr_d;   // next old-value read
  logic [SiteW-1:0] e_q, e_d;       // emit position, 0-based
  logic             ov_q, ov_d;
  logic [SiteW-1:0] idx_q, idx_d;
  logic             lst_q, lst_d;

  // effective lattice size and mirror sites
  logic [SiteW-1:0] m, lm, rm, em;
  logic             acc_in;

  always_comb begin
    if (sites_in_use_i < SiteW'(3))   m = SiteW'(3);
    else if (sites_in_use_i > MaxS)   m = MaxS;
    else                              m = sites_in_use_i;
    if (left_mirror_i < SiteW'(2))        lm = SiteW'(2);
    else if (left_mirror_i > m - 1'b1)    lm = m - 1'b1;
    else                                  lm = left_mirror_i;
    if (right_mirror_i < SiteW'(2))       rm = SiteW'(2);
    else if (right_mirror_i > m - 1'b1)   rm = m - 1'b1;
    else                                  rm = right_mirror_i;
    if (e_q == '0)              em = lm - 1'b1;
    else if (e_q == m - 1'b1)   em = rm - 1'b1;
    else                        em = e_q;
  end

  assign acc_in = in_valid_i && (state_q == S_LOAD);

  // next state and registered outputs
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    e_d     = e_q;
    ov_d    = ov_q;
    idx_d   = idx_q;
    lst_d   = lst_q;
    case (state_q)
      S_LOAD: begin
        if (acc_in) begin
          if (in_last_i) begin
            cnt_d   = '0;
            ptr_d   = '0;
            state_d = S_RD;
          end else if (cnt_q < MaxS) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_RD: state_d = S_SH;
      S_SH: begin
        ptr_d   = ptr_q + 1'b1;
        // two priming shifts, the third fills the window for site 2
        state_d = (ptr_q + 1'b1 < SiteW'(3)) ? S_RD : S_M1;
      end
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: begin
        if (ptr_q == m) begin
          e_d     = '0;
          state_d = S_ERD;
        end else begin
          state_d = S_RD;
        end
      end
      S_ERD: state_d = S_ELD;
      S_ELD: begin
        ov_d    = 1'b1;
        idx_d   = e_q + 1'b1;
        lst_d   = (e_q == m - 1'b1);
        state_d = S_EWT;
      end
      S_EWT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (lst_q) begin
            state_d = S_LOAD;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ptr_q   <= '0;
      e_q     <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      lst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      e_q     <= e_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      lst_q   <= lst_d;
    end
  end

  // datapath commands
  always_comb begin
    ctl_o.load_we = acc_in && (cnt_q < MaxS);
    ctl_o.shift   = (state_q == S_SH);
    ctl_o.st1     = (state_q == S_M1);
    ctl_o.st2     = (state_q == S_M2);
    ctl_o.st3     = (state_q == S_M3);
    ctl_o.st_wr   = (state_q == S_M4);
    ctl_o.out_ld  = (state_q == S_ELD);
  end

  logic [SiteW-1:0] wt_s, wr_s;
  assign wt_s = ptr_q - 1'b1;
  assign wr_s = ptr_q - SiteW'(2);

  assign ld_addr_o     = cnt_q[AddrW-1:0];
  assign rd_addr_o     = ptr_q[AddrW-1:0];
  assign wt_addr_o     = wt_s[AddrW-1:0];
  assign wr_addr_o     = wr_s[AddrW-1:0];
  assign em_addr_o     = em[AddrW-1:0];
  assign in_ready_o    = (state_q == S_LOAD);
  assign out_valid_o   = ov_q;
  assign site_index_o  = idx_q;
  assign last_result_o = lst_q;

endmodule

`default_nettype wire

// ----- rtl/lattice_propagator_stencil.sv -----
// ----------------------------------------------------------------------------
// lattice_propagator_stencil
// One generation step of a three-point chain propagator on a 1D lattice.
// ----------------------------------------------------------------------------
// Sites stream in one per cycle while the input is ready (site 1 first); the
// transaction with tlast set starts the step. The sequencer then primes a
// three-site window and runs each interior site through a read/shift/multiply/
// round/multiply/saturate sequence of the shared two-lane stencil pipeline,
// then emits all M sites; each result takes a new-value memory read, an
// output register load and the handshake, and waits while the sink is not
// ready. No input is taken from the last site's transaction until the last
// result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_propagator_stencil #(
  parameter int unsigned MaxSites = lps_pkg::MaxSitesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // site_weight[31:0], chain1_prev[63:32], chain2_prev[95:64]
  input  wire logic [95:0]                 s_axis_tdata,
  // in_range
  input  wire logic                        s_axis_tuser,
  input  wire logic                        s_axis_tlast,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // site_index[6:0], chain1_new[38:7], chain2_new[70:39], zero[71]
  output logic      [71:0]                 m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        cfg_we_i,
  input  wire logic [lps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lps_pkg::CoefW-1:0]   cfg_data_i
);
  import lps_pkg::*;

  localparam int unsigned AddrW = (MaxSites > 1) ? $clog2(MaxSites) : 1;

  // configuration registers
  logic [CoefW-1:0] wb_q, wf_q;
  logic [SiteW-1:0] sites_q, lmir_q, rmir_q;
  logic             two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q    <= '0;
      wf_q    <= '0;
      sites_q <= SiteW'(64);
      lmir_q  <= SiteW'(2);
      rmir_q  <= SiteW'(63);
      two_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWeightBack: wb_q    <= cfg_data_i;
        CfgWeightFwd:  wf_q    <= cfg_data_i;
        CfgSites:      sites_q <= cfg_data_i[SiteW-1:0];
        CfgLeftMirror: lmir_q  <= cfg_data_i[SiteW-1:0];
        CfgRightMirr:  rmir_q  <= cfg_data_i[SiteW-1:0];
        CfgTwoChain:   two_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ctl_t             ctl;
  logic [AddrW-1:0] ld_addr, rd_addr, wt_addr, wr_addr, em_addr;
  logic [SiteW-1:0] site_index;
  logic [DataW-1:0] chain1_new, chain2_new;

  lps_ctrl #(.MaxSites(MaxSites), .AddrW(AddrW)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_last_i      (s_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .site_index_o   (site_index),
    .last_result_o  (m_axis_tlast),
    .sites_in_use_i (sites_q),
    .left_mirror_i  (lmir_q),
    .right_mirror_i (rmir_q),
    .ctl_o          (ctl),
    .ld_addr_o      (ld_addr),
    .rd_addr_o      (rd_addr),
    .wt_addr_o      (wt_addr),
    .wr_addr_o      (wr_addr),
    .em_addr_o      (em_addr)
  );

  lps_datapath #(.MaxSites(MaxSites), .AddrW(AddrW)) u_dp (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .ld_addr_i     (ld_addr),
    .rd_addr_i     (rd_addr),
    .wt_addr_i     (wt_addr),
    .wr_addr_i     (wr_addr),
    .em_addr_i     (em_addr),
    .site_weight_i (s_axis_tdata[31:0]),
    .chain1_prev_i (s_axis_tdata[63:32]),
    .chain2_prev_i (s_axis_tdata[95:64]),
    .in_range_i    (s_axis_tuser),
    .weight_back_i (wb_q),
    .weight_fwd_i  (wf_q),
    .two_chain_i   (two_q),
    .chain1_new_o  (chain1_new),
    .chain2_new_o  (chain2_new)
  );

  assign m_axis_tdata = {1'b0, chain2_new, chain1_new, site_index};

`include "assert_macros.svh"

  // loading and emitting never overlap
  `ASSERT_IMP(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input ready during emit")
  // the final site starts the step and closes the input
  `ASSERT_NXT(a_last_closes, s_axis_tvalid && s_axis_tready && s_axis_tlast,
              !s_axis_tready, "input still open after last site")
  // the final result hands control back to loading
  `ASSERT_NXT(a_last_reopens, m_axis_tvalid && m_axis_tready && m_axis_tlast,
              s_axis_tready, "input not reopened after last result")

endmodule

`default_nettype wire

// ----- sim/lattice_propagator_stencil_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lattice_propagator_stencil_tb
// Drives batches of lattice sites through the stencil block and compares every
// emitted site against a local fixed-point prediction of the generation step.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_propagator_stencil_tb;
  import lps_pkg::*;

  localparam int unsigned Sites   = 64;
  localparam int unsigned IdleMax = 20000;
  localparam logic [32:0] HalfQ   = 33'd8388608;

  typedef struct packed {
    logic [6:0]  idx;
    logic [31:0] c1;
    logic [31:0] c2;
    logic        last;
  } site_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0, s_axis_tlast = 1'b0, s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] m_axis_tdata;
  logic m_axis_tlast, m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;

  lattice_propagator_stencil DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [24:0] k_back, k_fwd;
  logic [6:0]  n_sites, mir_l, mir_r;
  logic        dual;
  logic [31:0] wt_mem [Sites];
  logic [31:0] old1_mem [Sites];
  logic [31:0] old2_mem [Sites];
  logic        rng_mem [Sites];
  logic [6:0]  n_loaded;
  site_res_t   site_q[$];
  int          n_err = 0;
  int          idle_cnt = 0;
  int          burst_left = 0;
  int          stall_pat = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    n_err++;
  endtask

  // one site of the three-point update, in Q8.24 with clamp and saturate
  function automatic logic [31:0] site_update(logic [31:0] w, longint a, longint b,
                                              longint c);
    longint acc;
    logic [63:0] inner, prod;
    acc = b * 64'sd16777216 + longint'(k_back) * (a - b) + longint'(k_fwd) * (c - b);
    if (acc <= 0) return '0;
    inner = (acc + 64'd8388608) >> 24;
    prod  = 64'(w) * (inner >> 24) + ((64'(w) * inner[23:0] + HalfQ) >> 24);
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // store one accepted site; on the final site predict the whole generation
  task automatic predict_site(logic [95:0] d, logic rng, logic fin);
    int m, lm, rm;
    logic [31:0] n1 [Sites];
    logic [31:0] n2 [Sites];
    site_res_t r;
    longint a1, b1, c1, a2, b2, c2;
    if (n_loaded < Sites) begin
      wt_mem[n_loaded] = d[31:0];
      old1_mem[n_loaded] = d[63:32];
      old2_mem[n_loaded] = d[95:64];
      rng_mem[n_loaded] = rng;
      n_loaded++;
    end
    if (!fin) return;
    n_loaded = 0;
    m  = clampi(n_sites, 3, Sites);
    lm = clampi(mir_l, 2, m - 1);
    rm = clampi(mir_r, 2, m - 1);
    for (int z = 1; z + 1 < m; z++) begin
      a1 = old1_mem[z-1]; b1 = old1_mem[z]; c1 = old1_mem[z+1];
      a2 = old2_mem[z-1]; b2 = old2_mem[z]; c2 = old2_mem[z+1];
      if (dual && rng_mem[z]) begin
        n1[z] = site_update(wt_mem[z], a1 + a2, b1, c1 + c2);
        n2[z] = '0;
      end else begin
        n1[z] = site_update(wt_mem[z], a1, b1, c1);
        n2[z] = dual ? site_update(wt_mem[z], a2, b2, c2) : '0;
      end
    end
    n1[0] = n1[lm-1]; n2[0] = n2[lm-1];
    n1[m-1] = n1[rm-1]; n2[m-1] = n2[rm-1];
    for (int z = 0; z < m; z++) begin
      r.idx = 7'(z + 1); r.c1 = n1[z]; r.c2 = n2[z]; r.last = (z + 1 == m);
      site_q.push_back(r);
    end
  endtask

  // one register write; the enable is dropped by the caller
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgWeightBack: k_back = val;
      CfgWeightFwd:  k_fwd = val;
      CfgSites:      n_sites = val[6:0];
      CfgLeftMirror: mir_l = val[6:0];
      CfgRightMirr:  mir_r = val[6:0];
      CfgTwoChain:   dual = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [24:0] kb, logic [24:0] kf, int m, int lm, int rm, bit d);
    cfg_write(CfgWeightBack, kb);
    cfg_write(CfgWeightFwd, kf);
    cfg_write(CfgSites, 25'(m));
    cfg_write(CfgLeftMirror, 25'(lm));
    cfg_write(CfgRightMirr, 25'(rm));
    cfg_write(CfgTwoChain, 25'(d));
    cfg_we_i <= 1'b0;
  endtask

  // send one site with bursty gaps
  task automatic send_site(logic [31:0] w, logic [31:0] p1, logic [31:0] p2,
                           logic rng, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p2, p1, w};
    s_axis_tuser  <= rng;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_site({p2, p1, w}, rng, fin);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (site_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0400_0000);
      default: return $urandom();
    endcase
  endfunction

  // one batch of m sites; extra sites beyond capacity when over is set
  task automatic send_batch(int m, bit over = 0);
    int total;
    total = over ? m + $urandom_range(1, 4) : m;
    for (int i = 0; i < total; i++)
      send_site(rnd_val(), rnd_val(), rnd_val(), 1'($urandom()), i == total - 1);
  endtask

  // directed: extremes of data, single and two-chain, clamped settings
  task automatic test_directed();
    set_all(25'd0, 25'd0, 3, 2, 2, 0);
    send_site(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_site(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_site(32'h0100_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
    wait_drain();
    set_all(25'd16777216, 25'd16777216, 4, 1, 64, 1);
    send_site(32'h0100_0000, 32'h0, 32'h0, 1'b0, 1'b0);
    send_site(32'h0200_0000, 32'h0100_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_site(32'hFFFF_FFFF, 32'h0, 32'h0100_0000, 1'b0, 1'b0);
    send_site(32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    wait_drain();
    // weights above one, out-of-range sizes clamp
    set_all(25'h1FF_FFFF, 25'd0, 2, 0, 0, 1);
    send_batch(3);
    wait_drain();
    set_all(25'd0, 25'h1FF_FFFF, 0, 127, 127, 0);
    send_batch(3);
    wait_drain();
  endtask

  // full lattice with extra sites dropped past capacity
  task automatic test_overflow();
    set_all(25'd4194304, 25'd8388608, 127, 2, 63, 1);
    send_batch(64, 1);
    wait_drain();
  endtask

  // random settings, mostly small lattices
  task automatic test_random();
    int m, sent;
    sent = 0;
    while (sent < 400) begin
      m = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 10);
      set_all(25'($urandom_range(0, 25'h1FF_FFFF)), 25'($urandom_range(0, 16777216)), m,
              $urandom_range(0, 70), $urandom_range(0, 70), 1'($urandom()));
      for (int b = 0; b < 3; b++) begin
        send_batch(m);
        sent += m;
      end
      wait_drain();
    end
  endtask

  // receiver: pattern stalls, checks each result
  always @(posedge clk_i) begin
    site_res_t got, exp_r;
    stall_pat <= stall_pat + 1;
    m_axis_tready <= (stall_pat[5:4] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[6:0], m_axis_tdata[38:7], m_axis_tdata[70:39], m_axis_tlast};
      if (site_q.size() == 0) report("result with nothing expected");
      else begin
        exp_r = site_q.pop_front();
        if (got.idx != exp_r.idx)
          report($sformatf("site %0d got %0d", exp_r.idx, got.idx));
        if (got.c1 != exp_r.c1)
          report($sformatf("site %0d chain1 %h exp %h", exp_r.idx, got.c1, exp_r.c1));
        if (got.c2 != exp_r.c2)
          report($sformatf("site %0d chain2 %h exp %h", exp_r.idx, got.c2, exp_r.c2));
        if (got.last != exp_r.last)
          report($sformatf("site %0d tlast %b", exp_r.idx, got.last));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IdleMax) begin
      $display("FAIL lattice_propagator_stencil");
      $finish;
    end
  end

  initial begin
    k_back = '0; k_fwd = '0; n_sites = 7'd64; mir_l = 7'd2; mir_r = 7'd63;
    dual = 1'b0; n_loaded = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    wait_drain();
    if (n_err == 0 && site_q.size() == 0)
      $display("PASS lattice_propagator_stencil");
    else
      $display("FAIL lattice_propagator_stencil");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_datapath.sv
rtl/lps_ctrl.sv
rtl/lattice_propagator_stencil.sv
sim/lattice_propagator_stencil_tb.sv
